[rtl/lod_select_and_geomorph_core_defines.svh]
// Assertion macros shared by the block's modules.
`ifndef LOD_SELECT_AND_GEOMORPH_CORE_DEFINES_SVH
`define LOD_SELECT_AND_GEOMORPH_CORE_DEFINES_SVH
// Implication checked in the same cycle.
`define LSG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |-> cons) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define LSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`endif

[rtl/lsg_pkg.sv]
`timescale 1ns / 1ps
package lsg_pkg;
  localparam int MAX_LEVELS_DEF = 16;
  localparam int DIST_W = 24;
  localparam int POS_W = 24;
  localparam int CFG_W = 16;
  localparam int CNT_REG_W = 5;
  localparam int IDX_W = 2;
  localparam int LEVEL_W = 4;
  localparam int MORPH_W = 17;
  localparam int SNAP_QW = 23;
  localparam int QDEPTH = 4;
  localparam int BIAS_FLOOR = 4;
  localparam logic [CNT_REG_W-1:0] LEVEL_COUNT_RST = 5'd8;
  localparam logic [CFG_W-1:0] DISTANCE_BIAS_RST = 16'd4096;
  localparam logic [CFG_W-1:0] GRID_STRIDE_RST = 16'd256;

  typedef enum logic [IDX_W-1:0] {
    REG_LEVEL_COUNT   = 2'd0,
    REG_DISTANCE_BIAS = 2'd1,
    REG_GRID_STRIDE   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_REG_W-1:0] level_count;
    logic [CFG_W-1:0]     distance_bias;
    logic [CFG_W-1:0]     grid_stride;
  } cfg_t;

  function automatic logic [CFG_W-1:0] bias_floor(input logic [CFG_W-1:0] b);
    return (b < CFG_W'(BIAS_FLOOR)) ? CFG_W'(BIAS_FLOOR) : b;
  endfunction
endpackage

[rtl/lsg_front.sv]
`timescale 1ns / 1ps
module lsg_front #(
  parameter int MAX_LEVELS = lsg_pkg::MAX_LEVELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lsg_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lsg_pkg::DIST_W-1:0]          distance,
  input  logic signed [lsg_pkg::POS_W-1:0]    pos_x,
  input  logic signed [lsg_pkg::POS_W-1:0]    pos_z,
  input  logic                                full,
  output logic                                push,
  output logic [lsg_pkg::DIST_W-1:0]          q_dist,
  output logic signed [lsg_pkg::POS_W-1:0]    q_px,
  output logic signed [lsg_pkg::POS_W-1:0]    q_pz,
  output logic [$clog2(MAX_LEVELS)-1:0]       q_lvl,
  output logic                                q_last
);
  import lsg_pkg::*;

  localparam int LW = $clog2(MAX_LEVELS);
  localparam int CW = $clog2(MAX_LEVELS + 1);
  localparam int NK = MAX_LEVELS - 1;

  logic [CW-1:0] count;
  logic [CFG_W-1:0] bias;
  logic adv;
  logic [NK-1:0] ge;
  logic [LW-1:0] lvl_c;
  logic last_c;

  logic f1_valid, f2_valid;
  logic [DIST_W-1:0] f1_dist;
  logic signed [POS_W-1:0] f1_px, f1_pz;
  logic [NK-1:0] f1_ge;

  always_comb begin
    if (int'(cfg.level_count) > MAX_LEVELS) begin
      count = CW'(MAX_LEVELS);
    end else begin
      count = CW'(cfg.level_count);
    end
    bias = bias_floor(cfg.distance_bias);
    for (int k = 1; k <= NK; k++) begin
      ge[k-1] = ({distance, 1'b0} >= (DIST_W + 1)'(k * int'(bias))) && (k < int'(count));
    end
  end

  always_comb begin
    lvl_c = '0;
    for (int k = 1; k <= NK; k++) begin
      if (f1_ge[k-1]) begin
        lvl_c = LW'(k);
      end
    end
    last_c = (count == '0) || (CW'(lvl_c) == count - 1'b1);
  end

  assign adv      = !f2_valid || !full;
  assign in_stall = !adv;
  assign push     = f2_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= in_valid;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_dist <= distance;
      f1_px   <= pos_x;
      f1_pz   <= pos_z;
      f1_ge   <= ge;
      q_dist  <= f1_dist;
      q_px    <= f1_px;
      q_pz    <= f1_pz;
      q_lvl   <= lvl_c;
      q_last  <= last_c;
    end
  end
endmodule

[rtl/lsg_queue.sv]
`timescale 1ns / 1ps
`include "lod_select_and_geomorph_core_defines.svh"
module lsg_queue #(
  parameter int W     = 8,
  parameter int DEPTH = lsg_pkg::QDEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW-1:0] rp_next;
  logic [AW:0] count;

  assign full    = count == (AW + 1)'(DEPTH);
  assign empty   = count == '0;
  assign rp_next = pop ? rp + 1'b1 : rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (wp == rp_next)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[rp_next];
    end
  end

  `LSG_ASSERT_IMP(a_no_overflow, push, !full, "queue push while full")
  `LSG_ASSERT_IMP(a_no_underflow, pop, !empty, "queue pop while empty")
  `LSG_ASSERT_NEXT(a_fill_track, push && !pop, !empty, "queue lost a pushed word")
endmodule

[rtl/lsg_back.sv]
`timescale 1ns / 1ps
`include "lod_select_and_geomorph_core_defines.svh"
module lsg_back #(
  parameter int MAX_LEVELS = lsg_pkg::MAX_LEVELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lsg_pkg::cfg_t                       cfg,
  input  logic                                empty,
  output logic                                pop,
  input  logic [lsg_pkg::DIST_W-1:0]          h_dist,
  input  logic signed [lsg_pkg::POS_W-1:0]    h_px,
  input  logic signed [lsg_pkg::POS_W-1:0]    h_pz,
  input  logic [$clog2(MAX_LEVELS)-1:0]       h_lvl,
  input  logic                                h_last,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [lsg_pkg::LEVEL_W-1:0]         level,
  output logic [lsg_pkg::MORPH_W-1:0]         morph,
  output logic signed [lsg_pkg::POS_W-1:0]    out_x,
  output logic signed [lsg_pkg::POS_W-1:0]    out_z
);
  import lsg_pkg::*;

  localparam int LW  = $clog2(MAX_LEVELS);
  localparam int SQ  = SNAP_QW;
  localparam int NW  = DIST_W + 4;
  localparam int GW  = (((POS_W + 1) > (CFG_W + MAX_LEVELS)) ?
                        (POS_W + 1) : (CFG_W + MAX_LEVELS)) + 1;
  localparam int SNW = POS_W + 2;
  localparam int SW2 = SNW + MAX_LEVELS;
  localparam int NS  = SQ + 4;
  localparam logic [SNW:0] HALF_RANGE = (SNW + 1)'(1) << (POS_W - 1);

  typedef struct packed {
    logic [LW-1:0]    lvl;
    logic             en;
    logic             negx;
    logic             negz;
    logic [POS_W-1:0] apx;
    logic [POS_W-1:0] apz;
    logic [CFG_W-1:0] rx;
    logic [SQ-1:0]    qx;
    logic [CFG_W-1:0] rz;
    logic [SQ-1:0]    qz;
    logic [CFG_W-1:0] mr;
    logic [CFG_W-1:0] mq;
  } st_t;

  typedef struct packed {
    logic [LW-1:0]    lvl;
    logic [CFG_W-1:0] mq;
    logic             act;
    logic             negx;
    logic             negz;
    logic [POS_W-1:0] apx;
    logic [POS_W-1:0] apz;
    logic [SNW-1:0]   wx;
    logic [SNW-1:0]   wz;
    logic             upx;
    logic             upz;
  } tail_t;

  function automatic st_t div_step(input st_t a, input logic do_m,
                                   input logic [CFG_W-1:0] bv,
                                   input logic [CFG_W-1:0] stride_v);
    st_t o;
    logic [CFG_W:0] tx, tz, tm;
    o  = a;
    tx = {a.rx, a.qx[SQ-1]};
    tz = {a.rz, a.qz[SQ-1]};
    tm = {a.mr, a.mq[CFG_W-1]};
    if (tx >= {1'b0, stride_v}) begin
      o.rx = CFG_W'(tx - {1'b0, stride_v});
      o.qx = {a.qx[SQ-2:0], 1'b1};
    end else begin
      o.rx = tx[CFG_W-1:0];
      o.qx = {a.qx[SQ-2:0], 1'b0};
    end
    if (tz >= {1'b0, stride_v}) begin
      o.rz = CFG_W'(tz - {1'b0, stride_v});
      o.qz = {a.qz[SQ-2:0], 1'b1};
    end else begin
      o.rz = tz[CFG_W-1:0];
      o.qz = {a.qz[SQ-2:0], 1'b0};
    end
    if (do_m) begin
      if (tm >= {1'b0, bv}) begin
        o.mr = CFG_W'(tm - {1'b0, bv});
        o.mq = {a.mq[CFG_W-2:0], 1'b1};
      end else begin
        o.mr = tm[CFG_W-1:0];
        o.mq = {a.mq[CFG_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic neg, input logic [SNW:0] mag);
    logic [POS_W-1:0] r;
    if (neg) begin
      r = (mag > HALF_RANGE) ? {1'b1, {(POS_W - 1){1'b0}}} : POS_W'((SNW + 1)'(0) - mag);
    end else begin
      r = (mag > HALF_RANGE - 1'b1) ? {1'b0, {(POS_W - 1){1'b1}}} : POS_W'(mag);
    end
    return r;
  endfunction

  logic adv;
  logic [NS:0] sv;
  logic [CFG_W-1:0] b, stride;
  st_t st [SQ+1];
  st_t st0_c;
  tail_t p1, p2, p3;
  tail_t p1_c, p2_c, p3_c;

  logic [POS_W-1:0] ax, az;
  logic [NW-1:0] num, start;
  logic en0;
  logic [CFG_W:0] nm;
  logic [LW:0] sh1, sh2;
  logic [GW-1:0] gsx, gsz;
  logic [SQ+CFG_W-1:0] pmx, pmz;
  logic [SW2-1:0] shx, shz;
  logic [SNW-1:0] snx, snz;
  logic [SNW+CFG_W-1:0] mpx, mpz;
  logic [SNW:0] magx, magz;

  assign b      = bias_floor(cfg.distance_bias);
  assign stride = cfg.grid_stride;
  assign adv    = !(sv[NS] && out_stall);
  assign pop    = adv && !empty;

  always_comb begin
    ax    = h_px[POS_W-1] ? POS_W'(-h_px) : POS_W'(h_px);
    az    = h_pz[POS_W-1] ? POS_W'(-h_pz) : POS_W'(h_pz);
    num   = {h_dist, 4'b0000};
    start = NW'({h_lvl, 3'b110}) * NW'(b);
    en0   = !h_last && (num >= start);
    nm    = en0 ? (CFG_W + 1)'(num - start) : '0;
    sh1   = (LW + 1)'(h_lvl) + (LW + 1)'(1);
    sh2   = (LW + 1)'(h_lvl) + (LW + 1)'(2);
    gsx   = (GW'(ax) << 1) + (GW'(stride) << sh1);
    gsz   = (GW'(az) << 1) + (GW'(stride) << sh1);
    st0_c.lvl  = h_lvl;
    st0_c.en   = en0;
    st0_c.negx = h_px[POS_W-1];
    st0_c.negz = h_pz[POS_W-1];
    st0_c.apx  = ax;
    st0_c.apz  = az;
    st0_c.rx   = '0;
    st0_c.qx   = SQ'(gsx >> sh2);
    st0_c.rz   = '0;
    st0_c.qz   = SQ'(gsz >> sh2);
    st0_c.mr   = nm[CFG_W:1];
    st0_c.mq   = {nm[0], {(CFG_W - 1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (adv) begin
      sv <= {sv[NS-1:0], !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= st0_c;
    end
  end

  for (genvar i = 0; i < SQ; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        st[i+1] <= div_step(st[i], 1'(i < CFG_W), b, stride);
      end
    end
  end

  always_comb begin
    pmx = (SQ + CFG_W)'(st[SQ].qx) * (SQ + CFG_W)'(stride);
    pmz = (SQ + CFG_W)'(st[SQ].qz) * (SQ + CFG_W)'(stride);
    p1_c.lvl  = st[SQ].lvl;
    p1_c.mq   = st[SQ].mq;
    p1_c.act  = st[SQ].en && (st[SQ].mq != '0) && (stride != '0);
    p1_c.negx = st[SQ].negx;
    p1_c.negz = st[SQ].negz;
    p1_c.apx  = st[SQ].apx;
    p1_c.apz  = st[SQ].apz;
    p1_c.wx   = SNW'(pmx);
    p1_c.wz   = SNW'(pmz);
    p1_c.upx  = 1'b0;
    p1_c.upz  = 1'b0;
  end

  always_comb begin
    p2_c = p1;
    shx  = SW2'(p1.wx) << ((LW + 1)'(p1.lvl) + (LW + 1)'(1));
    shz  = SW2'(p1.wz) << ((LW + 1)'(p1.lvl) + (LW + 1)'(1));
    snx  = SNW'(shx);
    snz  = SNW'(shz);
    p2_c.upx = snx >= SNW'(p1.apx);
    p2_c.upz = snz >= SNW'(p1.apz);
    p2_c.wx  = p2_c.upx ? snx - SNW'(p1.apx) : SNW'(p1.apx) - snx;
    p2_c.wz  = p2_c.upz ? snz - SNW'(p1.apz) : SNW'(p1.apz) - snz;
  end

  always_comb begin
    p3_c = p2;
    mpx  = (SNW + CFG_W)'(p2.wx) * (SNW + CFG_W)'(p2.mq) + (SNW + CFG_W)'(32768);
    mpz  = (SNW + CFG_W)'(p2.wz) * (SNW + CFG_W)'(p2.mq) + (SNW + CFG_W)'(32768);
    p3_c.wx = p2.act ? mpx[SNW+CFG_W-1:CFG_W] : '0;
    p3_c.wz = p2.act ? mpz[SNW+CFG_W-1:CFG_W] : '0;
  end

  always_comb begin
    magx = p3.upx ? (SNW + 1)'(p3.apx) + (SNW + 1)'(p3.wx)
                  : (SNW + 1)'(p3.apx) - (SNW + 1)'(p3.wx);
    magz = p3.upz ? (SNW + 1)'(p3.apz) + (SNW + 1)'(p3.wz)
                  : (SNW + 1)'(p3.apz) - (SNW + 1)'(p3.wz);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1    <= p1_c;
      p2    <= p2_c;
      p3    <= p3_c;
      level <= LEVEL_W'(p3.lvl);
      morph <= MORPH_W'(p3.mq);
      out_x <= sat_pos(p3.negx, magx);
      out_z <= sat_pos(p3.negz, magz);
    end
  end

  assign out_valid = sv[NS];

  `LSG_ASSERT_NEXT(a_pop_lands, pop, sv[0], "popped word missing from first stage")
  `LSG_ASSERT_IMP(a_morph_rem, sv[SQ], st[SQ].mr < b, "morph remainder not below bias")
  `LSG_ASSERT_IMP(a_snap_rem, sv[SQ] && stride != '0, st[SQ].rx < stride && st[SQ].rz < stride, "snap remainder not below stride")
endmodule

[rtl/lod_select_and_geomorph_core.sv]
// Throughput: one vertex per cycle when nothing stalls; the front compare stage is registered,
// and the morph divider (16 steps) and the grid divider (23 steps) are pipelined one
// quotient bit per stage.
// A 4-word queue between level selection and the divider pipeline absorbs output stalls.
// rst clears all valid state and the queue; level_count, distance_bias and grid_stride
// reset to 8, 4096 and 256.
`timescale 1ns / 1ps
module lod_select_and_geomorph_core #(
  parameter int MAX_LEVELS = lsg_pkg::MAX_LEVELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lsg_pkg::IDX_W-1:0]           cfg_index,
  input  logic [lsg_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lsg_pkg::DIST_W-1:0]          distance,
  input  logic signed [lsg_pkg::POS_W-1:0]    pos_x,
  input  logic signed [lsg_pkg::POS_W-1:0]    pos_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lsg_pkg::LEVEL_W-1:0]         level,
  output logic [lsg_pkg::MORPH_W-1:0]         morph,
  output logic signed [lsg_pkg::POS_W-1:0]    out_x,
  output logic signed [lsg_pkg::POS_W-1:0]    out_z
);
  import lsg_pkg::*;

  localparam int LW = $clog2(MAX_LEVELS);
  localparam int QW = DIST_W + 2 * POS_W + LW + 1;

  cfg_t cfg;
  logic push, pop, full, empty;
  logic [QW-1:0] wdata, rdata;
  logic [DIST_W-1:0] q_dist, h_dist;
  logic signed [POS_W-1:0] q_px, q_pz, h_px, h_pz;
  logic [LW-1:0] q_lvl, h_lvl;
  logic q_last, h_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_count   <= LEVEL_COUNT_RST;
      cfg.distance_bias <= DISTANCE_BIAS_RST;
      cfg.grid_stride   <= GRID_STRIDE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LEVEL_COUNT:   cfg.level_count   <= cfg_data[CNT_REG_W-1:0];
        REG_DISTANCE_BIAS: cfg.distance_bias <= cfg_data;
        REG_GRID_STRIDE:   cfg.grid_stride   <= cfg_data;
        default: ;
      endcase
    end
  end

  lsg_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .distance (distance),
    .pos_x    (pos_x),
    .pos_z    (pos_z),
    .full     (full),
    .push     (push),
    .q_dist   (q_dist),
    .q_px     (q_px),
    .q_pz     (q_pz),
    .q_lvl    (q_lvl),
    .q_last   (q_last)
  );

  assign wdata = {q_dist, q_px, q_pz, q_lvl, q_last};
  assign {h_dist, h_px, h_pz, h_lvl, h_last} = rdata;

  lsg_queue #(.W(QW), .DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .pop   (pop),
    .rdata (rdata),
    .full  (full),
    .empty (empty)
  );

  lsg_back #(.MAX_LEVELS(MAX_LEVELS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .pop       (pop),
    .h_dist    (h_dist),
    .h_px      (h_px),
    .h_pz      (h_pz),
    .h_lvl     (h_lvl),
    .h_last    (h_last),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .level     (level),
    .morph     (morph),
    .out_x     (out_x),
    .out_z     (out_z)
  );
endmodule

[verif/lod_select_and_geomorph_core_test.sv]
`timescale 1ns / 1ps
module lod_select_and_geomorph_core_test;
  import lsg_pkg::*;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic [MORPH_W-1:0] morph;
    logic [POS_W-1:0]   out_x;
    logic [POS_W-1:0]   out_z;
  } vertex_t;

  class morph_scoreboard;
    vertex_t pending[$];
    int errors;
    logic [CNT_REG_W-1:0] level_count;
    logic [CFG_W-1:0] distance_bias;
    logic [CFG_W-1:0] grid_stride;

    function new();
      errors = 0;
      level_count = LEVEL_COUNT_RST;
      distance_bias = DISTANCE_BIAS_RST;
      grid_stride = GRID_STRIDE_RST;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_LEVEL_COUNT: level_count = v[CNT_REG_W-1:0];
        REG_DISTANCE_BIAS: distance_bias = v;
        REG_GRID_STRIDE: grid_stride = v;
        default: ;
      endcase
    endfunction

    function logic [POS_W-1:0] blend_axis(logic signed [POS_W-1:0] p, longint unsigned g,
                                          longint unsigned t);
      longint unsigned ap, snapped, mag, adj;
      bit neg;
      neg = p < 0;
      ap = neg ? longint'(-longint'(p)) : longint'(p);
      snapped = ((2 * ap + g) / (2 * g)) * g;
      if (snapped >= ap) begin
        adj = ((snapped - ap) * t + 32768) >> 16;
        mag = ap + adj;
      end else begin
        adj = ((ap - snapped) * t + 32768) >> 16;
        mag = ap - adj;
      end
      if (neg) return (mag > 8388608) ? 24'h800000 : POS_W'(-longint'(mag));
      return (mag > 8388607) ? 24'h7FFFFF : POS_W'(mag);
    endfunction

    function void note_vertex(logic [DIST_W-1:0] d, logic signed [POS_W-1:0] px,
                              logic signed [POS_W-1:0] pz);
      vertex_t e;
      longint unsigned cnt, b, raw, lvl, mph, num, start, g;
      cnt = (level_count > 16) ? 16 : level_count;
      b = (distance_bias < 4) ? 4 : distance_bias;
      lvl = 0;
      mph = 0;
      e.out_x = px;
      e.out_z = pz;
      if (cnt != 0) begin
        raw = (2 * longint'(d)) / b;
        lvl = (raw < cnt - 1) ? raw : cnt - 1;
        if (lvl < cnt - 1) begin
          num = 16 * longint'(d);
          start = (8 * lvl + 6) * b;
          if (num >= start) begin
            mph = ((num - start) * 32768) / b;
            if (mph > 65536) mph = 65536;
          end
          if (mph != 0 && grid_stride != 0) begin
            g = longint'(grid_stride) << (lvl + 1);
            e.out_x = blend_axis(px, g, mph);
            e.out_z = blend_axis(pz, g, mph);
          end
        end
      end
      e.level = lvl[LEVEL_W-1:0];
      e.morph = mph[MORPH_W-1:0];
      pending.push_back(e);
    endfunction

    function void check_vertex(vertex_t a);
      vertex_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word lvl=%0d morph=%0d x=%h z=%h", $time, a.level,
                 a.morph, a.out_x, a.out_z);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.level !== e.level) begin
        $display("%0t: level exp %0d got %0d", $time, e.level, a.level);
        errors++;
      end
      if (a.morph !== e.morph) begin
        $display("%0t: morph exp %0d got %0d", $time, e.morph, a.morph);
        errors++;
      end
      if (a.out_x !== e.out_x) begin
        $display("%0t: out_x exp %h got %h", $time, e.out_x, a.out_x);
        errors++;
      end
      if (a.out_z !== e.out_z) begin
        $display("%0t: out_z exp %h got %h", $time, e.out_z, a.out_z);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [DIST_W-1:0] distance = '0;
  logic signed [POS_W-1:0] pos_x = '0;
  logic signed [POS_W-1:0] pos_z = '0;
  logic out_valid;
  logic out_stall = 1;
  logic [LEVEL_W-1:0] level;
  logic [MORPH_W-1:0] morph;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_z;

  morph_scoreboard sb = new();
  int cycles = 0;
  bit hold_long = 0;
  bit sink_on = 0;
  bit quiet_sink = 0;

  lod_select_and_geomorph_core dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    vertex_t a;
    if (!rst && out_valid && !out_stall) begin
      a.level = level;
      a.morph = morph;
      a.out_x = out_x;
      a.out_z = out_z;
      sb.check_vertex(a);
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!sink_on || hold_long) out_stall <= 1;
      else if (quiet_sink) out_stall <= 0;
      else begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1;
          repeat (n) @(negedge clk);
        end
        out_stall <= 0;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_write <= 0;
  endtask

  task automatic send_vertex(logic [DIST_W-1:0] d, logic [POS_W-1:0] px,
                             logic [POS_W-1:0] pz, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1;
    distance <= d;
    pos_x <= px;
    pos_z <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_vertex(d, px, pz);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [DIST_W-1:0] rand_dist();
    logic [CFG_W-1:0] b;
    b = (sb.distance_bias < 4) ? 16'd4 : sb.distance_bias;
    case ($urandom_range(0, 3))
      0: return DIST_W'($urandom);
      1: return DIST_W'($urandom_range(0, 255));
      default: return DIST_W'($urandom_range(0, 18 * 32'(b)) / 2);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      1: return POS_W'($signed($urandom_range(0, 8000)) - 4000);
      default: return POS_W'($urandom);
    endcase
  endfunction

  task automatic random_phase(int items);
    repeat (items) send_vertex(rand_dist(), rand_pos(), rand_pos(), 1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    sink_on = 1;
    quiet_sink = 1;
    send_vertex(0, 0, 0, 0);
    send_vertex(24'hFFFFFF, 24'h7FFFFF, 24'h800000, 0);
    send_vertex(24'd14336, 24'd384, -24'sd384, 0);
    send_vertex(24'd16383, 24'd128, -24'sd128, 0);
    send_vertex(24'd3584, 24'h7FFF00, 24'h800100, 0);
    send_vertex(24'd32000, 24'h7FFFFF, 24'h800000, 0);
    send_vertex(24'd40000, 24'h555555, 24'hAAAAAA, 0);
    drain();
    quiet_sink = 0;
    write_reg(REG_LEVEL_COUNT, 0);
    send_vertex(24'd5000, 24'h123456, 24'h876543, 0);
    drain();
    write_reg(REG_LEVEL_COUNT, 31);
    write_reg(REG_DISTANCE_BIAS, 0);
    write_reg(REG_GRID_STRIDE, 16'hFFFF);
    send_vertex(24'd15, 24'h7FFFFF, 24'h800000, 0);
    send_vertex(24'd200, 24'h400000, 24'hC00000, 0);
    drain();
    write_reg(REG_GRID_STRIDE, 0);
    send_vertex(24'd14336, 24'd300, 24'd300, 0);
    drain();
    write_reg(REG_LEVEL_COUNT, 8);
    write_reg(REG_DISTANCE_BIAS, 4096);
    write_reg(REG_GRID_STRIDE, 256);
    // long receiver hold so the pipeline fills and stalls its input
    fork
      begin
        hold_long = 1;
        repeat (150) @(negedge clk);
        hold_long = 0;
      end
      random_phase(60);
    join
    drain();
    write_reg(REG_LEVEL_COUNT, 1);
    random_phase(100);
    drain();
    write_reg(REG_LEVEL_COUNT, 16);
    write_reg(REG_DISTANCE_BIAS, 65535);
    write_reg(REG_GRID_STRIDE, 1);
    random_phase(300);
    drain();
    write_reg(REG_LEVEL_COUNT, 5);
    write_reg(REG_DISTANCE_BIAS, 4);
    write_reg(REG_GRID_STRIDE, 65535);
    random_phase(300);
    drain();
    repeat (4) begin
      write_reg(REG_LEVEL_COUNT, CFG_W'($urandom_range(0, 31)));
      write_reg(REG_DISTANCE_BIAS, CFG_W'($urandom_range(0, 65535)));
      write_reg(REG_GRID_STRIDE, CFG_W'($urandom_range(0, 65535)));
      random_phase(180);
      drain();
    end
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
